FILE: rtl/adaptive_morse_decoder_assert.svh
// Assertion macros for the adaptive Morse decoder.
`ifndef ADAPTIVE_MORSE_DECODER_ASSERT_SVH
`define ADAPTIVE_MORSE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that cond holds at every clock edge outside reset.
`define AMDEC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define AMDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AMDEC_ASSERT(lbl, cond, msg)
`define AMDEC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/amdec_pkg.sv
// Shared types, constants and lookup functions of the adaptive Morse decoder.
`default_nettype none

package amdec_pkg;

  localparam int TIME_W    = 32;
  localparam int CODE_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_DAH = 1'd1;

  // Register values after reset.
  localparam logic [CFG_W-1:0] DIT_THR_RST = 16'd3;
  localparam logic [CFG_W-1:0] AVG_DAH_RST = 16'd15;

  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = "#";

  // One input beat held in the input register.
  typedef struct packed {
    logic              valid;
    logic              tone;
    logic [TIME_W-1:0] time_ms;
  } amdec_item_t;

  // One result beat on its way to the output register.
  typedef struct packed {
    logic              valid;
    logic              space;
    logic              chr;
    logic [CHAR_W-1:0] code;
  } amdec_res_t;

  // Letters and digits, indexed by the code with its leading start bit.
  localparam logic [CHAR_W-1:0] CHAR_TABLE [64] = '{
    "#", "#", "T", "E", "M", "N", "A", "I", "O", "G", "K", "D", "W", "R", "U", "S",
    "#", "#", "Q", "Z", "Y", "C", "X", "B", "J", "P", "#", "L", "#", "F", "V", "H",
    "0", "9", "#", "8", "#", "#", "#", "7", "#", "#", "#", "#", "#", "/", "-", "6",
    "1", "#", "#", "#", "#", "#", "#", "#", "2", "#", "#", "#", "3", "#", "4", "5"
  };

  // Maps a finished code to ASCII; long codes go through the punctuation list.
  function automatic logic [CHAR_W-1:0] char_lookup(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    c = CHAR_UNKNOWN;
    if (code > CODE_W'(63)) begin
      case (code)
        16'd71:  c = ":";
        16'd76:  c = ",";
        16'd84:  c = "!";
        16'd94:  c = "-";
        16'd97:  c = 8'd39;
        16'd101: c = "@";
        16'd106: c = ".";
        16'd115: c = "?";
        16'd246: c = "$";
        16'd122: c = "k";
        default: c = CHAR_UNKNOWN;
      endcase
    end else begin
      c = CHAR_TABLE[code[5:0]];
    end
    return c;
  endfunction

  // Unsigned divide by three through a reciprocal multiply.
  function automatic logic [TIME_W-2:0] div3(input logic [TIME_W-1:0] a);
    logic [2*TIME_W-1:0] p;
    p = {{TIME_W{1'b0}}, a} * 64'h0000_0000_AAAA_AAAB;
    return p[2*TIME_W-1:TIME_W+1];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/adaptive_morse_decoder.sv
// A beat waits in the input register; its result is registered in the output register for the out_ ports.
// Throughput: one input beat per cycle while the result side keeps taking beats; a result
// held under out_stall keeps the next beat in the input register and stalls the input.
// Reset (rst_n low, synchronous): threshold 3 ms, dah average 15 ms, timers
// clear, no element pending, character and word space idle; no result is held.
`default_nettype none

`include "adaptive_morse_decoder_assert.svh"

module adaptive_morse_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // Tone samples.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_tone,
  input  logic [amdec_pkg::TIME_W-1:0]    in_time_ms,
  // Decoded characters and word spaces.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_space_valid,
  output logic                            out_char_valid,
  output logic [amdec_pkg::CHAR_W-1:0]    out_char_code,
  // Register writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [amdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amdec_pkg::CFG_W-1:0]     cfg_data
);
  import amdec_pkg::*;

  amdec_item_t item;
  amdec_res_t  res;
  logic        out_free;
  logic        fire;

  // Register writes are always taken, so the port never pushes back.
  assign cfg_ready = 1'b1;

  // The held beat is processed whenever the output register can take its
  // result. Beats that cause no result still move on at this point.
  assign fire = item.valid && out_free;

  amdec_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tone    (in_tone),
    .in_time_ms (in_time_ms),
    .out_free   (out_free),
    .item       (item)
  );

  // All per-beat work is here: span timing, bounce rejection, dit or dah
  // classification with the adaptive threshold, and the character lookup.
  // After a dah the new threshold is divided out in the next cycle; the key-up
  // tests of the dah's own cycle and of the division's cycle work from the running average instead.
  amdec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .fire      (fire),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  amdec_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_space_valid (out_space_valid),
    .out_char_valid  (out_char_valid),
    .out_char_code   (out_char_code)
  );

  // A result beat always carries a space or a character.
  `AMDEC_ASSERT(a_res_has_flag, !out_valid || out_space_valid || out_char_valid, "empty result beat")

  // A beat without a character carries a zero code.
  `AMDEC_ASSERT(a_code_zero, !(out_valid && !out_char_valid) || (out_char_code == '0), "stray code")

  // A key-down beat never produces a result.
  `AMDEC_ASSERT_NEXT(a_tone_silent, fire && item.tone, !out_valid, "result from key-down beat")

endmodule

`default_nettype wire

FILE: rtl/amdec_in_stage.sv
// Input register of the adaptive Morse decoder.
`default_nettype none

module amdec_in_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_tone,
  input  logic [amdec_pkg::TIME_W-1:0] in_time_ms,
  input  logic                         out_free,
  output amdec_pkg::amdec_item_t       item
);
  import amdec_pkg::*;

  logic              valid_r;
  logic              tone_r;
  logic [TIME_W-1:0] time_r;

  // The held beat only waits when the output register cannot take its result.
  assign in_stall = valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tone_r <= in_tone;
      time_r <= in_time_ms;
    end
  end

  assign item = '{valid: valid_r, tone: tone_r, time_ms: time_r};

endmodule

`default_nettype wire

FILE: rtl/amdec_core.sv
// Timing state, element classifier and character decoder.
`default_nettype none

module amdec_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  amdec_pkg::amdec_item_t          item,
  input  logic                            fire,
  input  logic                            cfg_valid,
  input  logic [amdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [amdec_pkg::CFG_W-1:0]     cfg_data,
  output amdec_pkg::amdec_res_t           res
);
  import amdec_pkg::*;

  logic [TIME_W-1:0] thr_r, thr_nxt;
  logic [TIME_W-1:0] avg_r, avg_nxt;
  logic [TIME_W-1:0] down_start_r, down_start_nxt;
  logic [TIME_W-1:0] up_start_r, up_start_nxt;
  logic [TIME_W-1:0] down_len_r, down_len_nxt;
  logic              elem_pend_r, elem_pend_nxt;
  logic              char_idle_r, char_idle_nxt;
  logic              space_given_r, space_given_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              thr_pend_r, thr_pend_nxt;

  logic [TIME_W-1:0] now, up_start_eff, up, dl_eff, avg_new, avg_sel, half_up;
  logic [TIME_W+1:0] dl3, tri_up;
  logic [TIME_W:0]   avg_sum, up_inc;
  logic              cls, dit, dah, up_gt_thr, sp, ch;
  logic [CODE_W-1:0] code_cls;

  always_comb begin
    now          = item.time_ms;
    up_start_eff = (up_start_r == '0) ? now : up_start_r;
    up           = now - up_start_eff;
    dl_eff       = (down_start_r != '0) ? (now - down_start_r) : down_len_r;
    // The element counts when its length reaches a third of the threshold, rounded down.
    dl3      = {2'b00, dl_eff} + {1'b0, dl_eff, 1'b0} + (TIME_W+2)'(3);
    cls      = !elem_pend_r && (dl3 > {2'b00, thr_r});
    dit      = dl_eff < thr_r;
    dah      = cls && !dit;
    avg_sum  = {1'b0, dl_eff} + {1'b0, avg_r};
    avg_new  = avg_sum[TIME_W:1];
    avg_sel  = dah ? avg_new : avg_r;
    code_cls = cls ? {code_r[CODE_W-2:0], dit} : code_r;
    // While the threshold is two thirds of an average not yet divided out,
    // up > 2*floor(avg/3) is tested as avg < 3*ceil(up/2).
    up_inc   = {1'b0, up} + (TIME_W+1)'(1);
    half_up  = up_inc[TIME_W:1];
    tri_up   = {2'b00, half_up} + {1'b0, half_up, 1'b0};
    up_gt_thr = (dah || thr_pend_r) ? ({2'b00, avg_sel} < tri_up) : (up > thr_r);
    sp = ({1'b0, up} > {avg_r, 1'b0}) && !space_given_r;
    ch = !char_idle_r && up_gt_thr;
  end

  always_comb begin
    thr_nxt         = thr_r;
    avg_nxt         = avg_r;
    down_start_nxt  = down_start_r;
    up_start_nxt    = up_start_r;
    down_len_nxt    = down_len_r;
    elem_pend_nxt   = elem_pend_r;
    char_idle_nxt   = char_idle_r;
    space_given_nxt = space_given_r;
    code_nxt        = code_r;
    thr_pend_nxt    = 1'b0;

    // A dah leaves the new threshold to be divided out in the next cycle.
    if (thr_pend_r) begin
      thr_nxt = {div3(avg_r), 1'b0};
    end

    if (fire) begin
      if (item.tone) begin
        up_start_nxt  = '0;
        if (down_start_r == '0) begin
          down_start_nxt = now;
        end
        char_idle_nxt = 1'b0;
        elem_pend_nxt = 1'b0;
        if (code_r == '0) begin
          code_nxt = CODE_W'(1);
        end
      end else begin
        up_start_nxt   = up_start_eff;
        down_start_nxt = '0;
        down_len_nxt   = char_idle_r ? dl_eff : '0;
        elem_pend_nxt  = elem_pend_r || cls;
        code_nxt       = code_cls;
        avg_nxt        = avg_sel;
        thr_pend_nxt   = dah;
        if (sp) begin
          space_given_nxt = 1'b1;
        end
        if (ch) begin
          space_given_nxt = 1'b0;
          char_idle_nxt   = 1'b1;
          code_nxt        = '0;
        end
      end
    end

    if (cfg_valid && (cfg_index == CFG_DIT_THR)) begin
      thr_nxt = {{(TIME_W-CFG_W){1'b0}}, cfg_data};
    end
    if (cfg_valid && (cfg_index == CFG_AVG_DAH)) begin
      avg_nxt = {{(TIME_W-CFG_W){1'b0}}, cfg_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r         <= {{(TIME_W-CFG_W){1'b0}}, DIT_THR_RST};
      avg_r         <= {{(TIME_W-CFG_W){1'b0}}, AVG_DAH_RST};
      down_start_r  <= '0;
      up_start_r    <= '0;
      down_len_r    <= '0;
      elem_pend_r   <= 1'b0;
      char_idle_r   <= 1'b1;
      space_given_r <= 1'b1;
      code_r        <= '0;
      thr_pend_r    <= 1'b0;
    end else begin
      thr_r         <= thr_nxt;
      avg_r         <= avg_nxt;
      down_start_r  <= down_start_nxt;
      up_start_r    <= up_start_nxt;
      down_len_r    <= down_len_nxt;
      elem_pend_r   <= elem_pend_nxt;
      char_idle_r   <= char_idle_nxt;
      space_given_r <= space_given_nxt;
      code_r        <= code_nxt;
      thr_pend_r    <= thr_pend_nxt;
    end
  end

  assign res = '{
    valid: item.valid && !item.tone && (sp || ch),
    space: sp,
    chr:   ch,
    code:  ch ? char_lookup(code_cls) : '0
  };

endmodule

`default_nettype wire

FILE: rtl/amdec_out_stage.sv
// Output register of the adaptive Morse decoder.
`default_nettype none

module amdec_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  amdec_pkg::amdec_res_t        res,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_space_valid,
  output logic                         out_char_valid,
  output logic [amdec_pkg::CHAR_W-1:0] out_char_code
);
  import amdec_pkg::*;

  logic              valid_r;
  logic              space_r;
  logic              chr_r;
  logic [CHAR_W-1:0] code_r;

  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      space_r <= res.space;
      chr_r   <= res.chr;
      code_r  <= res.code;
    end
  end

  assign out_valid       = valid_r;
  assign out_space_valid = space_r;
  assign out_char_valid  = chr_r;
  assign out_char_code   = code_r;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the adaptive Morse decoder, driven by keyed Morse traffic and noise.
module tb;
  import amdec_pkg::*;

  // Cycles with no beat on any channel before the run is declared hung. The slowest
  // correct stretch is the receiver hold-off plus a few sender gaps.
  localparam int QUIET_LIMIT   = 4000;
  // Cycles to let pass once nothing is expected, so that a sample still in flight
  // inside the block has landed before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 140;
  localparam int HOLD_CYCLES   = 300;

  // Letters and digits, indexed by the keyed code including its leading start bit.
  localparam logic [8*64-1:0] MORSE_LETTERS =
    "##TEMNAIOGKDWRUS##QZYCXBJP#L#FVH09#8###7#####/-61#######2###3#45";
  // Codes with a punctuation meaning, each with its start bit.
  localparam logic [8*10-1:0] PUNCT_CODES =
    {8'd71, 8'd76, 8'd84, 8'd94, 8'd97, 8'd101, 8'd106, 8'd115, 8'd246, 8'd122};

  typedef struct packed {
    logic              tone;
    logic [TIME_W-1:0] t;
  } tone_sample_t;

  typedef struct packed {
    logic              space;
    logic              chr;
    logic [CHAR_W-1:0] code;
  } morse_out_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PULSE, STALL_HEAVY} stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_tone = 1'b0;
  logic [TIME_W-1:0]    in_time_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_space_valid;
  logic                 out_char_valid;
  logic [CHAR_W-1:0]    out_char_code;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIT_THR;
  logic [CFG_W-1:0]     cfg_data = '0;

  adaptive_morse_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tone         (in_tone),
    .in_time_ms      (in_time_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_space_valid (out_space_valid),
    .out_char_valid  (out_char_valid),
    .out_char_code   (out_char_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Samples waiting to be offered, and decoded symbols waiting to come out.
  tone_sample_t tone_q[$];
  morse_out_t   due_symbols[$];

  // Decoder state as the testbench sees it.
  logic [31:0] thr_ms;
  logic [31:0] dah_avg_ms;
  logic [31:0] key_down_at;
  logic [31:0] key_up_at;
  logic [31:0] down_span;
  logic        elem_held;
  logic        char_done;
  logic        space_sent;
  logic [15:0] morse_bits;

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          samples_seen = 0;
  logic        sample_taken = 1'b0;
  logic        progress;
  morse_out_t  want;

  // Works out what one accepted tone sample does to the decoder and queues the
  // symbol it releases, if any. A timer holding zero counts as not running.
  task automatic decode_sample(input logic tone, input logic [31:0] now);
    logic [31:0]       up;
    logic [32:0]       sum;
    logic              sp;
    logic              ch;
    logic [CHAR_W-1:0] ascii;
    sp = 1'b0;
    ch = 1'b0;
    ascii = '0;
    if (tone) begin
      // Key down: the key-up timer stops, and a fresh code gets its start bit.
      if (key_up_at != 0) key_up_at = 0;
      if (key_down_at == 0) key_down_at = now;
      char_done = 1'b0;
      elem_held = 1'b0;
      if (morse_bits == 0) morse_bits = 16'd1;
    end else begin
      if (key_up_at == 0) key_up_at = now;
      up = now - key_up_at;
      // A gap beyond twice the dah average closes the word, once per word.
      if ({1'b0, up} > {dah_avg_ms, 1'b0} && !space_sent) begin
        space_sent = 1'b1;
        sp = 1'b1;
      end
      if (key_down_at != 0) begin
        down_span = now - key_down_at;
        key_down_at = 0;
      end
      // Spans under a third of the threshold are bounce and leave the element open.
      if (!elem_held && down_span >= thr_ms / 3) begin
        morse_bits = morse_bits << 1;
        elem_held = 1'b1;
        if (down_span < thr_ms) begin
          morse_bits = morse_bits + 16'd1;
        end else begin
          // A dah pulls the average toward itself and the threshold follows at 2/3.
          sum = {1'b0, down_span} + {1'b0, dah_avg_ms};
          dah_avg_ms = sum[32:1];
          thr_ms = (dah_avg_ms / 3) * 2;
        end
      end
      if (!char_done) begin
        if (up > thr_ms) begin
          space_sent = 1'b0;
          ch = 1'b1;
          if (morse_bits > 63) begin
            case (morse_bits)
              16'd71:  ascii = ":";
              16'd76:  ascii = ",";
              16'd84:  ascii = "!";
              16'd94:  ascii = "-";
              16'd97:  ascii = 8'h27;
              16'd101: ascii = "@";
              16'd106: ascii = ".";
              16'd115: ascii = "?";
              16'd246: ascii = "$";
              16'd122: ascii = "k";
              default: ascii = "#";
            endcase
          end else begin
            ascii = MORSE_LETTERS[8*(63 - morse_bits[5:0]) +: 8];
          end
          char_done = 1'b1;
          morse_bits = '0;
        end
        down_span = '0;
      end
      if (sp || ch) due_symbols.push_back('{sp, ch, ascii});
    end
  endtask

  // Monitor: the predictor follows every accepted beat on the three channels, and
  // each result beat is checked against the oldest symbol that is due. The same
  // process counts quiet cycles as a watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      thr_ms       = {16'd0, DIT_THR_RST};
      dah_avg_ms   = {16'd0, AVG_DAH_RST};
      key_down_at  = '0;
      key_up_at    = '0;
      down_span    = '0;
      elem_held    = 1'b0;
      char_done    = 1'b1;
      space_sent   = 1'b1;
      morse_bits   = '0;
      sample_taken = 1'b0;
    end else begin
      progress = 1'b0;
      sample_taken = in_valid && !in_stall;
      // A register write also loads the live value at once.
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          CFG_DIT_THR: thr_ms = {16'd0, cfg_data};
          CFG_AVG_DAH: dah_avg_ms = {16'd0, cfg_data};
          default: ;
        endcase
      end
      if (sample_taken) begin
        progress = 1'b1;
        samples_seen++;
        decode_sample(in_tone, in_time_ms);
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (due_symbols.size() == 0) begin
          $error("result beat with nothing due: space %0b char %0b code %0h",
                 out_space_valid, out_char_valid, out_char_code);
          mismatches++;
        end else begin
          want = due_symbols.pop_front();
          if (out_space_valid !== want.space) begin
            $error("space_valid mismatch: expected %0b, got %0b", want.space, out_space_valid);
            mismatches++;
          end
          if (out_char_valid !== want.chr) begin
            $error("char_valid mismatch: expected %0b, got %0b", want.chr, out_char_valid);
            mismatches++;
          end
          if (out_char_code !== want.code) begin
            $error("char_code mismatch: expected %0h, got %0h", want.code, out_char_code);
            mismatches++;
          end
        end
      end
      if (progress) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Driver: offers queued samples in bursts of random length separated by random
  // gaps. A new sample goes out only once the one on the port was taken.
  int           burst_left = 0;
  int           gap_left = 0;
  tone_sample_t drv_sample;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (gap_left > 0 || tone_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        drv_sample = tone_q.pop_front();
        in_valid   <= 1'b1;
        in_tone    <= drv_sample.tone;
        in_time_ms <= drv_sample.t;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // A quarter of the bursts run straight into the next one with no gap.
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stalls in modes that change at random. Twice during the
  // run it holds off for a long stretch so that a result is held inside the block
  // and the input side gets stalled while the driver keeps offering.
  int          hold_left = 0;
  int          holds_done = 0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && samples_seen >= 500) ||
                 (holds_done == 1 && samples_seen >= 1200)) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
        STALL_PULSE: out_stall <= (mode_left % 4 == 0);
        default:     out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Stimulus generation. The keyed traffic follows a unit length: dits near one
  // unit, dahs near three, gaps of one, three and seven units between elements,
  // characters and words.
  logic [31:0] t_now = '0;
  logic [31:0] last_up = '0;
  int          unit_ms = 1;
  int          pushed = 0;

  task automatic push_sample(input logic tone, input logic [31:0] t);
    tone_q.push_back('{tone, t});
    pushed++;
  endtask

  task automatic key_element(input logic is_dit);
    int span;
    int n;
    int b;
    int k;
    // Now and then a short bounce comes first and must be ignored.
    if ($urandom_range(0, 11) == 0) begin
      b = $urandom_range(0, unit_ms / 2);
      push_sample(1'b1, t_now);
      push_sample(1'b0, t_now + b);
      t_now = t_now + b + $urandom_range(1, unit_ms);
    end
    span = is_dit ? unit_ms * $urandom_range(8, 13) / 10 : unit_ms * $urandom_range(26, 34) / 10;
    if (span < 1) span = 1;
    n = $urandom_range(1, 3);
    for (k = 0; k < n; k++) push_sample(1'b1, t_now + span * k / n);
    last_up = t_now + span;
    push_sample(1'b0, last_up);
  endtask

  // Key-up stretch after an element, with up to n_hi samples spread across it. The
  // next key-down starts where the stretch ends.
  task automatic key_gap(input int lo_tenths, input int hi_tenths, input int n_lo, input int n_hi);
    int gap;
    int n;
    int k;
    gap = unit_ms * $urandom_range(lo_tenths, hi_tenths) / 10;
    if (gap < 1) gap = 1;
    n = $urandom_range(n_lo, n_hi);
    for (k = 1; k <= n; k++) push_sample(1'b0, last_up + gap * k / n);
    t_now = last_up + gap;
  endtask

  // One character: mostly letters and digits, then punctuation, unknown long
  // codes, and codes that fill or overflow the code register (some all dahs,
  // which wrap the code to zero once it overflows).
  task automatic key_random_char();
    int          pick;
    int          len;
    int          i;
    logic [31:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      bits = $urandom_range(2, 63);
    end else if (pick < 85) begin
      bits = {24'd0, PUNCT_CODES[8*$urandom_range(0, 9) +: 8]};
    end else if (pick < 95) begin
      bits = $urandom;
    end else begin
      bits = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom;
    end
    if (pick < 85) begin
      // Elements are the bits below the start bit, most significant first.
      len = 0;
      for (i = 0; i < 16; i++) if (bits[i]) len = i;
    end else if (pick < 95) begin
      len = $urandom_range(7, 9);
    end else begin
      len = $urandom_range(15, 18);
    end
    for (i = len - 1; i >= 0; i--) begin
      key_element(bits[i]);
      if (i > 0) key_gap(6, 13, 0, 1);
    end
  endtask

  // A word ends on a long gap with one to three samples in it; when only one, it lies
  // deep in the gap and brings the word space and the last character out together.
  task automatic key_word();
    int nchars;
    int c;
    nchars = $urandom_range(1, 5);
    for (c = 0; c < nchars; c++) begin
      key_random_char();
      if (c == nchars - 1) key_gap(65, 90, 1, 3);
      else key_gap(25, 40, 1, 2);
    end
  endtask

  // Samples with no Morse shape at all: random tone, random or extreme times.
  task automatic key_noise();
    int          n;
    int          k;
    logic [31:0] t;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t = t_now + $urandom_range(0, 4 * unit_ms);
        4, 5, 6:    t = $urandom;
        7:          t = '0;
        8:          t = '1;
        default:    t = t_now;
      endcase
      push_sample(1'($urandom_range(0, 1)), t);
    end
    t_now = t_now + $urandom_range(1, 10 * unit_ms);
  endtask

  // Waits until every sample was taken and every due symbol came out, then lets
  // the pipeline drain of samples that release nothing.
  task automatic settle();
    while (tone_q.size() != 0 || in_valid || due_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One phase: registers are written only once the block is idle, then a run of
  // words and noise starts from a random time, sometimes just short of the wrap.
  task automatic run_phase(input logic do_cfg, input logic [CFG_W-1:0] thr,
                           input logic [CFG_W-1:0] avg, input int unit, input int budget);
    int mark;
    settle();
    if (do_cfg) begin
      write_reg(CFG_DIT_THR, thr);
      write_reg(CFG_AVG_DAH, avg);
    end
    unit_ms = unit;
    case ($urandom_range(0, 3))
      0:       t_now = $urandom;
      1:       t_now = 32'hFFFF_FFFF - $urandom_range(0, 40 * unit);
      default: t_now = $urandom_range(1, 1000);
    endcase
    mark = pushed;
    while (pushed - mark < budget) begin
      if ($urandom_range(0, 6) == 0) key_noise();
      else key_word();
    end
  endtask

  initial begin
    int u;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed start under the reset settings. A key-down at time zero leaves the
    // timer unset so the next sample starts it; then a single dit gives 'E' and a
    // jump to the top of the time range gives a lone word space.
    push_sample(1'b1, 32'd0);
    push_sample(1'b1, 32'd5);
    push_sample(1'b0, 32'd6);
    push_sample(1'b0, 32'd10);
    push_sample(1'b0, 32'hFFFF_FFFF);
    // Three dits, a dah, a dit and a dah across the time wrap, with a key-up
    // landing on zero; the code with its start bit is the 'k' entry.
    push_sample(1'b1, 32'hFFFF_FFF8);
    push_sample(1'b0, 32'hFFFF_FFFA);
    push_sample(1'b1, 32'hFFFF_FFFB);
    push_sample(1'b0, 32'hFFFF_FFFD);
    push_sample(1'b1, 32'hFFFF_FFFE);
    push_sample(1'b0, 32'd0);
    push_sample(1'b1, 32'd1);
    push_sample(1'b0, 32'd4);
    push_sample(1'b1, 32'd5);
    push_sample(1'b0, 32'd7);
    push_sample(1'b1, 32'd8);
    push_sample(1'b0, 32'd14);
    push_sample(1'b0, 32'd20);
    // A zero-length bounce, retried by the next key-up with a cleared length;
    // the bare start bit then decodes as unknown.
    push_sample(1'b1, 32'd30);
    push_sample(1'b0, 32'd30);
    push_sample(1'b0, 32'd31);
    push_sample(1'b0, 32'd40);
    // One dit closed by a single far sample: space and character in one beat.
    push_sample(1'b1, 32'd50);
    push_sample(1'b0, 32'd51);
    push_sample(1'b0, 32'd100);

    run_phase(1'b0, DIT_THR_RST, AVG_DAH_RST, 2, PHASE_ITEMS);
    run_phase(1'b1, 16'd0, 16'd0, $urandom_range(1, 10), PHASE_ITEMS);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 20000, PHASE_ITEMS);
    u = $urandom_range(2, 60);
    run_phase(1'b1, 16'(2 * u), 16'(3 * u), u, PHASE_ITEMS);
    run_phase(1'b1, 16'($urandom), 16'($urandom), $urandom_range(1, 200), PHASE_ITEMS);
    u = $urandom_range(100, 5000);
    run_phase(1'b1, 16'(2 * u), 16'(3 * u), u, PHASE_ITEMS);
    run_phase(1'b1, 16'hFFFF, 16'd0, $urandom_range(1, 50), PHASE_ITEMS);
    u = $urandom_range(5, 30);
    run_phase(1'b1, 16'(2 * u), 16'(3 * u), u, PHASE_ITEMS);
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
